/* hdl/booth_signed_multiplier_defines.svh */
// Assertion macros shared by the Booth multiplier RTL.
// Included by the cell and the top level; depends on nothing else.
`ifndef BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH
`define BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH

// Next-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("booth multiplier check failed");

// Next-cycle implication that is also checked through reset.
`define BSM_ASSERT_NEXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("booth multiplier check failed");

`endif

/* hdl/bsm_pkg.sv */
// Shared constants, codes and the per-stage data type of the Booth multiplier.
// Used by the interfaces, the cell and the top level; depends on nothing.
package bsm_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int PRODUCT_BITS = 64;
    // Operand width the multiplier works on (4 to 32).
    localparam int OPERAND_BITS = 32;
    // One guard bit keeps every add and subtract exact.
    localparam int ACC_BITS     = OPERAND_BITS + 1;

    // Booth action codes for the pair {q[0], q_minus_1}.
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] mcand;
        logic [ACC_BITS-1:0]     acc;
        logic [OPERAND_BITS-1:0] q;
        logic                    qm1;
    } t_cell_data;

endpackage

/* hdl/bsm_ifs.sv */
// Valid/ready channel interfaces for the operand pair and the product.
// Depends on bsm_pkg for the field widths.
interface bsm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bsm_pkg::FIELD_BITS-1:0]  multiplicand;
    logic signed [bsm_pkg::FIELD_BITS-1:0]  multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [bsm_pkg::PRODUCT_BITS-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

/* hdl/bsm_cell.sv */
// One Booth step with its pipeline register and local valid/ready control.
// Depends on bsm_pkg and the assertion macro header.
`include "booth_signed_multiplier_defines.svh"

module bsm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bsm_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bsm_pkg::t_cell_data o_data
);

    logic                         r_valid;
    bsm_pkg::t_cell_data          r_data;
    bsm_pkg::t_cell_data          n_data;
    logic [bsm_pkg::ACC_BITS-1:0] w_mcand_ext;
    logic [bsm_pkg::ACC_BITS-1:0] w_sum;

    // Add or subtract the multiplicand, then shift {acc, q, qm1} right arithmetically.
    always_comb begin
        w_mcand_ext = {i_data.mcand[bsm_pkg::OPERAND_BITS-1], i_data.mcand};
        unique case ({i_data.q[0], i_data.qm1})
            bsm_pkg::BOOTH_SUB: begin
                w_sum = i_data.acc - w_mcand_ext;
            end
            bsm_pkg::BOOTH_ADD: begin
                w_sum = i_data.acc + w_mcand_ext;
            end
            default: begin
                w_sum = i_data.acc;
            end
        endcase
        n_data.mcand = i_data.mcand;
        n_data.qm1   = i_data.q[0];
        n_data.q     = {w_sum[0], i_data.q[bsm_pkg::OPERAND_BITS-1:1]};
        n_data.acc   = {w_sum[bsm_pkg::ACC_BITS-1], w_sum[bsm_pkg::ACC_BITS-1:1]};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    `BSM_ASSERT_NEXT(a_cell_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_data))
    `BSM_ASSERT_NEXT(a_cell_step, i_clk, i_rst_n, i_valid && o_ready,
                     r_data.mcand == $past(i_data.mcand) && r_data.qm1 == $past(i_data.q[0]))

endmodule

/* hdl/booth_signed_multiplier.sv */
// Radix-2 Booth signed multiplier: a chain of OPERAND_BITS cells, one Booth step each.
// Throughput is one operand pair per cycle while o_out.ready stays high; every cell holds its own register stage.
// Reset (i_rst_n low, synchronous) clears the valid bit of every cell; data is not reset.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_cell and the assertion macro header.
`include "booth_signed_multiplier_defines.svh"

module booth_signed_multiplier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsm_in_if.sink    i_in,
    bsm_out_if.source o_out
);

    // Stage k is the data entering cell k; stage OPERAND_BITS is the last cell's register.
    logic                w_valid [0:bsm_pkg::OPERAND_BITS];
    logic                w_ready [0:bsm_pkg::OPERAND_BITS];
    bsm_pkg::t_cell_data w_data  [0:bsm_pkg::OPERAND_BITS];

    // The chain starts with a zero accumulator and a zero extra bit. Only the low
    // OPERAND_BITS bits of each operand take part, the multiplicand read as signed.
    assign w_valid[0]       = i_in.valid;
    assign i_in.ready       = w_ready[0];
    assign w_data[0].mcand  = i_in.multiplicand[bsm_pkg::OPERAND_BITS-1:0];
    assign w_data[0].acc    = '0;
    assign w_data[0].q      = i_in.multiplier[bsm_pkg::OPERAND_BITS-1:0];
    assign w_data[0].qm1    = 1'b0;

    // Each cell takes a transfer when its own register is empty or is being emptied,
    // so a stalled output only backs up the cells that actually hold items.
    for (genvar g = 0; g < bsm_pkg::OPERAND_BITS; g++) begin : g_cell
        bsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // The last cell's register is the output register. The product is the accumulator
    // over the multiplier register, sign-extended (or trimmed of the guard bit) to 64 bits.
    assign o_out.valid = w_valid[bsm_pkg::OPERAND_BITS];
    assign w_ready[bsm_pkg::OPERAND_BITS] = o_out.ready;
    assign o_out.product = bsm_pkg::PRODUCT_BITS'($signed({w_data[bsm_pkg::OPERAND_BITS].acc,
                                                          w_data[bsm_pkg::OPERAND_BITS].q}));

    // Reset empties the whole chain, and an accepted pair lands in the first cell.
    `BSM_ASSERT_NEXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_out.valid && !w_valid[1])
    `BSM_ASSERT_NEXT(a_first_fill, i_clk, i_rst_n, i_in.valid && i_in.ready, w_valid[1])
    `BSM_ASSERT_NEXT(a_first_mcand, i_clk, i_rst_n, i_in.valid && i_in.ready,
                     w_data[1].mcand == $past(i_in.multiplicand[bsm_pkg::OPERAND_BITS-1:0]))

endmodule
